[rtl/core/bgrs_pkg.sv]
// Shared types and constants for the barrier growth rate select block.
package bgrs_pkg;

  localparam int TOTAL_W    = 38;
  localparam int IDX_OUT_W  = 6;
  localparam int LEN_IO_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BAR_W      = 24;
  localparam int DIV_W      = 8;
  localparam int RATE_W     = 32;
  localparam int FIL_W      = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // request kinds; any other code acts as a query
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_GROW  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SLOPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILAMENTS  = 3'd6;

  typedef struct packed {
    logic              linear;
    logic [BAR_W-1:0]  barrier_pos;
    logic [DIV_W-1:0]  dper;
    logic [RATE_W-1:0] full_rate;
    logic [BAR_W-1:0]  ramp_width;
    logic [RATE_W-1:0] ramp_slope;
  } rate_cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_OUT_W-1:0] index;
    logic [LEN_IO_W-1:0]  length;
    logic [TOTAL_W-1:0]   draw;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   total;
    logic [IDX_OUT_W-1:0] index;
    logic                 found;
    logic [LEN_IO_W-1:0]  length;
  } res_t;

endpackage

[rtl/core/barrier_growth_rate_select.sv]
// Top level: configuration registers, table, rate pipeline, sequencer, result register.
//
//  port group   dir  handshake            payload
//  request      in   req_valid/req_stall  req_type, filament_index, length_value, random_draw
//  response     out  rsp_valid/rsp_stall  total_rate, chosen_index, found, chosen_length
//  config       in   cfg_write            cfg_index, cfg_data
//
// The table is read one entry a cycle through the single read port, and each rate
// goes through a four stage pipeline. After reset a clearing pass zeroes the table;
// req_stall is high until it ends. Config writes are taken at any time.
// A new item is accepted while the previous result waits in the output register.
module barrier_growth_rate_select
  import bgrs_pkg::*;
#(
  parameter int MAX_FILAMENTS = 64,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            req_type,
  input  logic [IDX_OUT_W-1:0]  filament_index,
  input  logic [LEN_IO_W-1:0]   length_value,
  input  logic [TOTAL_W-1:0]    random_draw,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [TOTAL_W-1:0]    total_rate,
  output logic [IDX_OUT_W-1:0]  chosen_index,
  output logic                  found,
  output logic [LEN_IO_W-1:0]   chosen_length,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int IDX_W = (MAX_FILAMENTS > 1) ? $clog2(MAX_FILAMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_FILAMENTS + 1);

  logic              rate_mode;
  logic [BAR_W-1:0]  barrier_pos;
  logic [DIV_W-1:0]  divisions;
  logic [RATE_W-1:0] full_rate;
  logic [BAR_W-1:0]  ramp_width;
  logic [RATE_W-1:0] ramp_slope;
  logic [FIL_W-1:0]  filaments;

  rate_cfg_t         rcfg;
  req_t              req;
  res_t              res;
  logic [CNT_W-1:0]  active_n;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [LENGTH_BITS-1:0] ram_wdata, ram_rdata;
  logic                   pipe_valid, pipe_last;
  logic [LENGTH_BITS-1:0] pipe_len;
  logic [IDX_W-1:0]       pipe_idx;
  logic                   rate_valid, rate_last;
  logic [RATE_W-1:0]      rate;
  logic [IDX_W-1:0]       rate_idx;
  logic [LENGTH_BITS-1:0] rate_len;
  logic                   res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode   <= 1'b0;
      barrier_pos <= '0;
      divisions   <= DIV_W'(1);
      full_rate   <= '0;
      ramp_width  <= '0;
      ramp_slope  <= '0;
      filaments   <= FIL_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RATE_MODE:  rate_mode   <= cfg_data[0];
        CFG_BARRIER:    barrier_pos <= cfg_data[BAR_W-1:0];
        CFG_DIVS:       divisions   <= cfg_data[DIV_W-1:0];
        CFG_FULL_RATE:  full_rate   <= cfg_data[RATE_W-1:0];
        CFG_RAMP_WIDTH: ramp_width  <= cfg_data[BAR_W-1:0];
        CFG_RAMP_SLOPE: ramp_slope  <= cfg_data[RATE_W-1:0];
        CFG_FILAMENTS:  filaments   <= cfg_data[FIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rcfg.linear      = rate_mode;
    rcfg.barrier_pos = barrier_pos;
    rcfg.dper        = (divisions == '0) ? DIV_W'(1) : divisions;
    rcfg.full_rate   = full_rate;
    rcfg.ramp_width  = ramp_width;
    rcfg.ramp_slope  = ramp_slope;
    if (32'(filaments) > 32'(MAX_FILAMENTS)) begin
      active_n = CNT_W'(MAX_FILAMENTS);
    end else begin
      active_n = CNT_W'(filaments);
    end
  end

  assign req.kind   = req_type;
  assign req.index  = filament_index;
  assign req.length = length_value;
  assign req.draw   = random_draw;

  bgrs_len_ram #(
    .MAX_FILAMENTS (MAX_FILAMENTS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgrs_rate_unit #(
    .MAX_FILAMENTS (MAX_FILAMENTS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_rate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (rcfg),
    .in_valid  (pipe_valid),
    .in_len    (pipe_len),
    .in_idx    (pipe_idx),
    .in_last   (pipe_last),
    .out_valid (rate_valid),
    .out_rate  (rate),
    .out_idx   (rate_idx),
    .out_len   (rate_len),
    .out_last  (rate_last)
  );

  bgrs_seq #(
    .MAX_FILAMENTS (MAX_FILAMENTS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .active_n   (active_n),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .pipe_valid (pipe_valid),
    .pipe_len   (pipe_len),
    .pipe_idx   (pipe_idx),
    .pipe_last  (pipe_last),
    .rate_valid (rate_valid),
    .rate       (rate),
    .rate_idx   (rate_idx),
    .rate_len   (rate_len),
    .rate_last  (rate_last),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      total_rate    <= res.total;
      chosen_index  <= res.index;
      found         <= res.found;
      chosen_length <= res.length;
    end
  end

  // one item in flight: after an accept, no further item until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while a previous item was still in work");

  // a handed-over result always shows up in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> rsp_valid)
    else $error("sequencer result was dropped");

  // without a pick, the index and length fields stay clear
  a_no_pick_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !found) |-> (chosen_index == '0 && chosen_length == '0))
    else $error("pick fields set without a chosen filament");

endmodule

[rtl/core/bgrs_len_ram.sv]
// Filament length table: one write port, one registered read port.
module bgrs_len_ram #(
  parameter int  MAX_FILAMENTS = 64,
  parameter int  LENGTH_BITS   = 16,
  localparam int IDX_W         = (MAX_FILAMENTS > 1) ? $clog2(MAX_FILAMENTS) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [LENGTH_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [IDX_W-1:0]       raddr,
  output logic [LENGTH_BITS-1:0] rdata
);
  logic [LENGTH_BITS-1:0] mem [MAX_FILAMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bgrs_rate_unit.sv]
// Per-filament growth rate pipeline: extent multiply, classify, slope multiply, select.
module bgrs_rate_unit
  import bgrs_pkg::*;
#(
  parameter int  MAX_FILAMENTS = 64,
  parameter int  LENGTH_BITS   = 16,
  localparam int IDX_W         = (MAX_FILAMENTS > 1) ? $clog2(MAX_FILAMENTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rate_cfg_t              cfg,
  input  logic                   in_valid,
  input  logic [LENGTH_BITS-1:0] in_len,
  input  logic [IDX_W-1:0]       in_idx,
  input  logic                   in_last,
  output logic                   out_valid,
  output logic [RATE_W-1:0]      out_rate,
  output logic [IDX_W-1:0]       out_idx,
  output logic [LENGTH_BITS-1:0] out_len,
  output logic                   out_last
);
  localparam int EXT_W  = LENGTH_BITS + DIV_W;
  localparam int CW     = ((EXT_W > BAR_W) ? EXT_W : BAR_W) + 1;
  localparam int PROD_W = BAR_W + RATE_W;

  localparam logic [1:0] RC_ZERO = 2'd0;
  localparam logic [1:0] RC_FULL = 2'd1;
  localparam logic [1:0] RC_PROD = 2'd2;

  logic                   v1, v2, v3;
  logic [LENGTH_BITS-1:0] s1_len, s2_len, s3_len;
  logic [IDX_W-1:0]       s1_idx, s2_idx, s3_idx;
  logic                   s1_last, s2_last, s3_last;
  logic [EXT_W-1:0]       s1_ext;
  logic [BAR_W-1:0]       s2_dist;
  logic [1:0]             s2_cls, s3_cls;
  logic [PROD_W-1:0]      s3_prod;

  logic [CW-1:0]    ext_c, bp_c, dp_c, diff_c;
  logic             step_ok, over;
  logic [BAR_W-1:0] room;
  logic [1:0]       cls;
  logic [RATE_W-1:0] rate_sel;

  always_comb begin
    ext_c   = CW'(s1_ext);
    bp_c    = CW'(cfg.barrier_pos);
    dp_c    = CW'(cfg.dper);
    // floor(bp / D) > L  is the same as  (L + 1) * D <= bp
    step_ok = (ext_c + dp_c) <= bp_c;
    over    = ext_c > bp_c;
    diff_c  = bp_c - ext_c;
    room    = diff_c[BAR_W-1:0];
    if (!cfg.linear) begin
      cls = step_ok ? RC_FULL : RC_ZERO;
    end else if (over) begin
      cls = RC_ZERO;
    end else if (room >= cfg.ramp_width) begin
      cls = RC_FULL;
    end else if (room < BAR_W'(cfg.dper)) begin
      cls = RC_ZERO;
    end else begin
      cls = RC_PROD;
    end
  end

  always_comb begin
    unique case (s3_cls)
      RC_FULL: rate_sel = cfg.full_rate;
      RC_PROD: rate_sel = (|s3_prod[PROD_W-1:RATE_W]) ? {RATE_W{1'b1}}
                                                       : s3_prod[RATE_W-1:0];
      default: rate_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1_len   <= in_len;
    s1_idx   <= in_idx;
    s1_last  <= in_last;
    s1_ext   <= EXT_W'(in_len) * EXT_W'(cfg.dper);

    s2_len   <= s1_len;
    s2_idx   <= s1_idx;
    s2_last  <= s1_last;
    s2_dist  <= room;
    s2_cls   <= cls;

    s3_len   <= s2_len;
    s3_idx   <= s2_idx;
    s3_last  <= s2_last;
    s3_cls   <= s2_cls;
    s3_prod  <= PROD_W'(s2_dist) * PROD_W'(cfg.ramp_slope);

    out_len  <= s3_len;
    out_idx  <= s3_idx;
    out_last <= s3_last;
    out_rate <= rate_sel;
  end

endmodule

[rtl/core/bgrs_seq.sv]
// Item sequencer: table clear, scan with rate sum and weighted pick, write-back.
module bgrs_seq
  import bgrs_pkg::*;
#(
  parameter int  MAX_FILAMENTS = 64,
  parameter int  LENGTH_BITS   = 16,
  localparam int IDX_W         = (MAX_FILAMENTS > 1) ? $clog2(MAX_FILAMENTS) : 1,
  localparam int CNT_W         = $clog2(MAX_FILAMENTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req,
  input  logic [CNT_W-1:0]       active_n,
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [LENGTH_BITS-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [IDX_W-1:0]       ram_raddr,
  input  logic [LENGTH_BITS-1:0] ram_rdata,
  output logic                   pipe_valid,
  output logic [LENGTH_BITS-1:0] pipe_len,
  output logic [IDX_W-1:0]       pipe_idx,
  output logic                   pipe_last,
  input  logic                   rate_valid,
  input  logic [RATE_W-1:0]      rate,
  input  logic [IDX_W-1:0]       rate_idx,
  input  logic [LENGTH_BITS-1:0] rate_len,
  input  logic                   rate_last,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res
);
  localparam int ACC_W = CNT_W + RATE_W;
  localparam int LB    = LENGTH_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state;
  logic [CNT_W-1:0]   clr_cnt;
  logic [CNT_W-1:0]   rd_cnt;
  logic               iss_v;
  logic [IDX_W-1:0]   iss_idx;
  logic               iss_last;
  req_t               cur;
  logic [ACC_W-1:0]   acc;
  logic [TOTAL_W-1:0] left;
  logic               picked;
  logic [IDX_W-1:0]   pick_idx;
  logic [LB-1:0]      pick_len;

  logic                       clr_last, rd_last, accept;
  logic                       wr_in_range, found_c;
  logic [IDX_W+IDX_OUT_W-1:0] wr_addr_x;
  logic [LB+LEN_IO_W-1:0]     wr_len_x;
  logic [LB-1:0]              grown_len;
  logic [LB+LEN_IO_W-1:0]     grown_x;
  logic [IDX_W+IDX_OUT_W-1:0] pick_idx_x;
  logic [ACC_W+TOTAL_W-1:0]   acc_x;
  logic [TOTAL_W-1:0]         total_c;
  logic [TOTAL_W-1:0]         rate_x;

  assign clr_last  = clr_cnt == CNT_W'(MAX_FILAMENTS - 1);
  assign rd_last   = rd_cnt == (active_n - CNT_W'(1));
  assign accept    = req_valid && !req_stall;
  assign req_stall = state != ST_IDLE;
  assign res_valid = state == ST_DONE;

  assign ram_re     = state == ST_SCAN;
  assign ram_raddr  = rd_cnt[IDX_W-1:0];
  assign pipe_valid = iss_v;
  assign pipe_idx   = iss_idx;
  assign pipe_last  = iss_last;
  assign pipe_len   = ram_rdata;

  assign wr_in_range = 32'(cur.index) < 32'(MAX_FILAMENTS);
  assign wr_addr_x   = {{IDX_W{1'b0}}, cur.index};
  assign wr_len_x    = {{LB{1'b0}}, cur.length};
  assign grown_len   = (pick_len == {LB{1'b1}}) ? pick_len : pick_len + LB'(1);
  assign grown_x     = {{LEN_IO_W{1'b0}}, grown_len};
  assign pick_idx_x  = {{IDX_OUT_W{1'b0}}, pick_idx};
  assign found_c     = (cur.kind == REQ_GROW) && picked;
  assign acc_x       = {{TOTAL_W{1'b0}}, acc};
  assign total_c     = (acc_x > {{ACC_W{1'b0}}, TOTAL_MAX}) ? TOTAL_MAX
                                                            : acc_x[TOTAL_W-1:0];
  assign rate_x      = TOTAL_W'(rate);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt[IDX_W-1:0];
    ram_wdata = '0;
    priority if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == ST_FIN && cur.kind == REQ_WRITE && wr_in_range) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_x[IDX_W-1:0];
      ram_wdata = wr_len_x[LB-1:0];
    end else if (state == ST_FIN && found_c) begin
      ram_we    = 1'b1;
      ram_waddr = pick_idx;
      ram_wdata = grown_len;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      rd_cnt  <= '0;
      iss_v   <= 1'b0;
    end else begin
      iss_v <= state == ST_SCAN;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CNT_W'(1);
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          rd_cnt <= '0;
          if (accept) begin
            state <= (active_n == '0) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_cnt <= rd_cnt + CNT_W'(1);
          if (rd_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (rate_valid && rate_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    iss_idx  <= rd_cnt[IDX_W-1:0];
    iss_last <= rd_last;
    if (accept) begin
      cur    <= req;
      acc    <= '0;
      left   <= req.draw;
      picked <= 1'b0;
    end else if (rate_valid) begin
      acc <= acc + ACC_W'(rate);
      // first filament whose rate covers what is left of the draw
      if (!picked) begin
        if (left < rate_x) begin
          picked   <= 1'b1;
          pick_idx <= rate_idx;
          pick_len <= rate_len;
        end else begin
          left <= left - rate_x;
        end
      end
    end
    if (state == ST_FIN) begin
      res.total  <= total_c;
      res.found  <= found_c;
      res.index  <= found_c ? pick_idx_x[IDX_OUT_W-1:0] : '0;
      res.length <= found_c ? grown_x[LEN_IO_W-1:0] : '0;
    end
  end

endmodule
